// ===== hw/rtl/wscd_pkg.sv =====
// ============================================================================
// wscd_pkg
// shared constants, codes and types of the windowed size correlation detector
// ============================================================================
`default_nettype none

package wscd_pkg;

   localparam int DEF_MAX_WINDOW = 1024;
   localparam int DEF_SIZE_BITS  = 16;

   localparam int PKT_BITS  = 16;
   localparam int WIN_BITS  = 11;
   localparam int THR_BITS  = 16;
   localparam int CORR_BITS = 16;
   localparam int CSR_BITS  = 32;
   localparam int ADDR_BITS = 3;

   localparam int MIN_SAMPLES = 10;

   localparam logic [WIN_BITS-1:0] WINDOW_RESET = 11'd1000;
   localparam logic [THR_BITS-1:0] THRESH_RESET = 16'd45875;

   localparam logic REG_WINDOW = 1'b0;
   localparam logic REG_THRESH = 1'b1;

   typedef enum logic [1:0] {
      OP_REC_IN  = 2'd0,
      OP_REC_OUT = 2'd1,
      OP_QUERY   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef struct packed {
      logic                        valid;
      logic signed [CORR_BITS-1:0] correlation;
      logic                        correlated;
      logic                        enough_samples;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/wscd_ram.sv =====
// ============================================================================
// wscd_ram
// generic single write port, single read port ram with registered read data
// ============================================================================
`default_nettype none

module wscd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wscd_queue.sv =====
// ============================================================================
// wscd_queue
// short command queue between the front and back parts
// ============================================================================
`default_nettype none

module wscd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head_data,
   output logic                  empty,
   output logic                  full
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wscd_front.sv =====
// ============================================================================
// wscd_front
// accepts requests, keeps ring pointers and counts, queues commands
// ============================================================================
`default_nettype none

module wscd_front #(
   parameter int MAX_WINDOW = wscd_pkg::DEF_MAX_WINDOW,
   parameter int SIZE_BITS  = wscd_pkg::DEF_SIZE_BITS,
   parameter int QW         = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          q_full,
   input  wire logic [1:0]                    req_type,
   input  wire logic [wscd_pkg::PKT_BITS-1:0] req_pkt_size,
   input  wire logic [wscd_pkg::WIN_BITS-1:0] window_size,
   output logic                               busy,
   output logic                               push,
   output logic      [QW-1:0]                 push_data
);

   localparam int SW = (SIZE_BITS < wscd_pkg::PKT_BITS) ? SIZE_BITS : wscd_pkg::PKT_BITS;
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int NW = $clog2(MAX_WINDOW + 1);

   logic [AW-1:0]       in_old_ff, in_old_in, out_old_ff, out_old_in;
   logic [NW-1:0]       in_cnt_ff, in_cnt_in, out_cnt_ff, out_cnt_in;
   logic [NW-1:0]       win;
   logic [2*AW+NW-1:0]  in_next, out_next;
   logic                accept;
   wscd_pkg::op_type    op;
   logic [SW-1:0]       size;
   logic [AW-1:0]       fld_a, fld_b;
   logic [NW-1:0]       fld_n;
   logic                fld_enough;

   function automatic logic [2*AW+NW-1:0] ring_next(
      input logic [AW-1:0] oldest,
      input logic [NW-1:0] count,
      input logic [NW-1:0] lim
   );
      logic [NW:0]   sum;
      logic [NW:0]   cnt1;
      logic [NW+1:0] t;
      logic [AW-1:0] pos;
      logic [AW-1:0] nold;
      logic [NW-1:0] ncnt;
      sum = (NW+1)'(oldest) + (NW+1)'(count);
      if (sum >= (NW+1)'(MAX_WINDOW)) begin
         sum = sum - (NW+1)'(MAX_WINDOW);
      end
      pos  = AW'(sum);
      cnt1 = (NW+1)'(count) + (NW+1)'(1);
      t    = (NW+2)'(pos) + (NW+2)'(1) + (NW+2)'(MAX_WINDOW) - (NW+2)'(lim);
      if (t >= (NW+2)'(2 * MAX_WINDOW)) begin
         t = t - (NW+2)'(2 * MAX_WINDOW);
      end else if (t >= (NW+2)'(MAX_WINDOW)) begin
         t = t - (NW+2)'(MAX_WINDOW);
      end
      if (cnt1 > (NW+1)'(lim)) begin
         nold = AW'(t);
         ncnt = lim;
      end else begin
         nold = oldest;
         ncnt = NW'(cnt1);
      end
      return {nold, ncnt, pos};
   endfunction

   always_comb begin
      if (32'(window_size) > 32'(MAX_WINDOW)) begin
         win = NW'(MAX_WINDOW);
      end else begin
         win = NW'(window_size);
      end
   end

   assign busy     = q_full;
   assign accept   = start && !q_full;
   assign op       = wscd_pkg::op_type'(req_type);
   assign size     = SW'(req_pkt_size);
   assign in_next  = ring_next(in_old_ff, in_cnt_ff, win);
   assign out_next = ring_next(out_old_ff, out_cnt_ff, win);

   always_comb begin
      in_old_in  = in_old_ff;
      in_cnt_in  = in_cnt_ff;
      out_old_in = out_old_ff;
      out_cnt_in = out_cnt_ff;
      push       = 1'b0;
      fld_a      = '0;
      fld_b      = '0;
      fld_n      = '0;
      fld_enough = 1'b0;
      case (op)
         wscd_pkg::OP_REC_IN: begin
            push  = accept;
            fld_a = in_next[AW-1:0];
            if (accept) begin
               {in_old_in, in_cnt_in} = in_next[2*AW+NW-1:AW];
            end
         end
         wscd_pkg::OP_REC_OUT: begin
            push  = accept;
            fld_a = out_next[AW-1:0];
            if (accept) begin
               {out_old_in, out_cnt_in} = out_next[2*AW+NW-1:AW];
            end
         end
         wscd_pkg::OP_QUERY: begin
            push       = accept;
            fld_a      = in_old_ff;
            fld_b      = out_old_ff;
            fld_n      = (in_cnt_ff < out_cnt_ff) ? in_cnt_ff : out_cnt_ff;
            fld_enough = (in_cnt_ff >= NW'(wscd_pkg::MIN_SAMPLES)) &&
                         (out_cnt_ff >= NW'(wscd_pkg::MIN_SAMPLES));
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign push_data = {req_type, size, fld_a, fld_b, fld_n, fld_enough};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_old_ff  <= '0;
         in_cnt_ff  <= '0;
         out_old_ff <= '0;
         out_cnt_ff <= '0;
      end else begin
         in_old_ff  <= in_old_in;
         in_cnt_ff  <= in_cnt_in;
         out_old_ff <= out_old_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wscd_back.sv =====
// ============================================================================
// wscd_back
// ring storage, window walk, shared serial multiplier and coefficient search
// ============================================================================
`default_nettype none

module wscd_back #(
   parameter int MAX_WINDOW = wscd_pkg::DEF_MAX_WINDOW,
   parameter int SIZE_BITS  = wscd_pkg::DEF_SIZE_BITS,
   parameter int QW         = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [QW-1:0]                 head_data,
   input  wire logic                          q_empty,
   input  wire logic [wscd_pkg::THR_BITS-1:0] threshold,
   output logic                               pop,
   output wscd_pkg::rsp_type                  rsp
);

   localparam int SW  = (SIZE_BITS < wscd_pkg::PKT_BITS) ? SIZE_BITS : wscd_pkg::PKT_BITS;
   localparam int AW  = $clog2(MAX_WINDOW);
   localparam int NW  = $clog2(MAX_WINDOW + 1);
   localparam int SXW = SW + NW;
   localparam int SQW = 2 * SW + NW;
   localparam int PW  = NW + SQW;
   localparam int DW  = 2 * PW;
   localparam int CW  = DW + 33;
   localparam int BW  = (PW > 32) ? PW : 32;
   localparam int CB  = wscd_pkg::CORR_BITS;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b00000000001,
      ST_WALK     = 11'b00000000010,
      ST_DRAIN    = 11'b00000000100,
      ST_PROD     = 11'b00000001000,
      ST_DIFF     = 11'b00000010000,
      ST_MUL_DEN  = 11'b00000100000,
      ST_MUL_NUM  = 11'b00001000000,
      ST_MUL_THR  = 11'b00010000000,
      ST_SRCH_SUM = 11'b00100000000,
      ST_SRCH_CMP = 11'b01000000000,
      ST_FINISH   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic [1:0]    h_op_raw;
   logic [SW-1:0] h_size;
   logic [AW-1:0] h_a, h_b;
   logic [NW-1:0] h_n;
   logic          h_enough;

   logic          we_in_ram, we_out_ram;
   logic [SW-1:0] x_rd, y_rd;

   logic [AW-1:0]  rd_a_ff, rd_a_in, rd_b_ff, rd_b_in;
   logic [NW-1:0]  n_ff, n_in, left_ff, left_in;
   logic           v1_ff, v1_in, v2_ff;
   logic [SW-1:0]  x_ff, y_ff;
   logic [2*SW-1:0] xx_ff, yy_ff, xy_ff;
   logic [SXW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [SQW-1:0] sxx_ff, sxx_in, syy_ff, syy_in, sxy_ff, sxy_in;
   logic [PW-1:0]  pa_ff, pb_ff, nxx_ff, nyy_ff, sxsx_ff, sysy_ff;
   logic [PW-1:0]  mag_ff, mag_in;
   logic           neg_ff, neg_in;
   logic [CW-1:0]  acc_ff, acc_in, mca_ff, mca_in;
   logic [BW-1:0]  mcb_ff, mcb_in;
   logic [DW-1:0]  den_ff, den_in, nsq_ff, nsq_in;
   logic [CW-1:0]  tden_ff, tden_in;
   logic [CW-1:0]  s_ff, s_in, u_ff, u_in, d_ff, d_in, trial_ff, trial_in;
   logic [CW-1:0]  rhs;
   logic [15:0]    q_ff, q_in;
   logic [3:0]     bit_ff, bit_in;
   logic [31:0]    tsq;
   logic [CB-1:0]  corr_val;
   wscd_pkg::rsp_type rsp_ff, rsp_in;

   assign {h_op_raw, h_size, h_a, h_b, h_n, h_enough} = head_data;

   assign we_in_ram  = (state_ff == ST_IDLE) && !q_empty &&
                       (wscd_pkg::op_type'(h_op_raw) == wscd_pkg::OP_REC_IN);
   assign we_out_ram = (state_ff == ST_IDLE) && !q_empty &&
                       (wscd_pkg::op_type'(h_op_raw) == wscd_pkg::OP_REC_OUT);

   wscd_ram #(.WIDTH(SW), .DEPTH(MAX_WINDOW)) u_ram_in (
      .clock   (clock),
      .wr_en   (we_in_ram),
      .wr_addr (h_a),
      .wr_data (h_size),
      .rd_addr (rd_a_ff),
      .rd_data (x_rd)
   );

   wscd_ram #(.WIDTH(SW), .DEPTH(MAX_WINDOW)) u_ram_out (
      .clock   (clock),
      .wr_en   (we_out_ram),
      .wr_addr (h_a),
      .wr_data (h_size),
      .rd_addr (rd_b_ff),
      .rd_data (y_rd)
   );

   assign tsq = 32'(threshold) * 32'(threshold);
   assign rhs = CW'(nsq_ff) << 30;
   assign pop = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      if (neg_ff) begin
         corr_val = CB'(-q_ff);
      end else if (q_ff > 16'd32767) begin
         corr_val = CB'(16'd32767);
      end else begin
         corr_val = CB'(q_ff);
      end
   end

   // window walk pipeline: read, square, accumulate
   always_ff @(posedge clock) begin
      x_ff  <= x_rd;
      y_ff  <= y_rd;
      xx_ff <= (2*SW)'(x_rd) * (2*SW)'(x_rd);
      yy_ff <= (2*SW)'(y_rd) * (2*SW)'(y_rd);
      xy_ff <= (2*SW)'(x_rd) * (2*SW)'(y_rd);
   end

   always_comb begin
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      sxx_in = sxx_ff;
      syy_in = syy_ff;
      sxy_in = sxy_ff;
      if (state_ff == ST_IDLE) begin
         sx_in  = '0;
         sy_in  = '0;
         sxx_in = '0;
         syy_in = '0;
         sxy_in = '0;
      end else if (v2_ff) begin
         sx_in  = sx_ff + SXW'(x_ff);
         sy_in  = sy_ff + SXW'(y_ff);
         sxx_in = sxx_ff + SQW'(xx_ff);
         syy_in = syy_ff + SQW'(yy_ff);
         sxy_in = sxy_ff + SQW'(xy_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      rd_a_in  = rd_a_ff;
      rd_b_in  = rd_b_ff;
      n_in     = n_ff;
      left_in  = left_ff;
      v1_in    = 1'b0;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      acc_in   = acc_ff;
      mca_in   = mca_ff;
      mcb_in   = mcb_ff;
      den_in   = den_ff;
      nsq_in   = nsq_ff;
      tden_in  = tden_ff;
      s_in     = s_ff;
      u_in     = u_ff;
      d_in     = d_ff;
      trial_in = trial_ff;
      q_in     = q_ff;
      bit_in   = bit_ff;
      rsp_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && (wscd_pkg::op_type'(h_op_raw) == wscd_pkg::OP_QUERY)) begin
               if (!h_enough) begin
                  rsp_in.valid = 1'b1;
               end else begin
                  rd_a_in  = h_a;
                  rd_b_in  = h_b;
                  n_in     = h_n;
                  left_in  = h_n;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            v1_in   = 1'b1;
            rd_a_in = (rd_a_ff == AW'(MAX_WINDOW - 1)) ? '0 : rd_a_ff + AW'(1);
            rd_b_in = (rd_b_ff == AW'(MAX_WINDOW - 1)) ? '0 : rd_b_ff + AW'(1);
            left_in = left_ff - NW'(1);
            if (left_ff == NW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in = pa_ff < pb_ff;
            mag_in = (pa_ff < pb_ff) ? pb_ff - pa_ff : pa_ff - pb_ff;
            if ((nxx_ff == sxsx_ff) || (nyy_ff == sysy_ff)) begin
               rsp_in.valid          = 1'b1;
               rsp_in.enough_samples = 1'b1;
               state_in              = ST_IDLE;
            end else begin
               acc_in   = '0;
               mca_in   = CW'(nxx_ff - sxsx_ff);
               mcb_in   = BW'(nyy_ff - sysy_ff);
               state_in = ST_MUL_DEN;
            end
         end
         ST_MUL_DEN, ST_MUL_NUM, ST_MUL_THR: begin
            if (mcb_ff == '0) begin
               acc_in = '0;
               if (state_ff == ST_MUL_DEN) begin
                  den_in   = DW'(acc_ff);
                  mca_in   = CW'(mag_ff);
                  mcb_in   = BW'(mag_ff);
                  state_in = ST_MUL_NUM;
               end else if (state_ff == ST_MUL_NUM) begin
                  nsq_in   = DW'(acc_ff);
                  mca_in   = CW'(den_ff);
                  mcb_in   = BW'(tsq);
                  state_in = ST_MUL_THR;
               end else begin
                  tden_in  = acc_ff;
                  s_in     = '0;
                  u_in     = '0;
                  d_in     = CW'(den_ff) << 30;
                  q_in     = '0;
                  bit_in   = 4'd15;
                  state_in = ST_SRCH_SUM;
               end
            end else begin
               if (mcb_ff[0]) begin
                  acc_in = acc_ff + mca_ff;
               end
               mca_in = mca_ff << 1;
               mcb_in = mcb_ff >> 1;
            end
         end
         ST_SRCH_SUM: begin
            trial_in = s_ff + u_ff + d_ff;
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            // try setting this bit of q: (q + 2^b)^2 * den against num^2 * 2^30
            if (trial_ff <= rhs) begin
               s_in         = trial_ff;
               u_in         = (u_ff >> 1) + d_ff;
               q_in[bit_ff] = 1'b1;
            end else begin
               u_in = u_ff >> 1;
            end
            d_in = d_ff >> 2;
            if (bit_ff == 4'd0) begin
               state_in = ST_FINISH;
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = ST_SRCH_SUM;
            end
         end
         ST_FINISH: begin
            rsp_in.valid          = 1'b1;
            rsp_in.correlation    = corr_val;
            rsp_in.correlated     = (CW'(nsq_ff) << 32) > tden_ff;
            rsp_in.enough_samples = 1'b1;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= v1_in;
         v2_ff    <= v1_ff;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff  <= rd_a_in;
      rd_b_ff  <= rd_b_in;
      n_ff     <= n_in;
      left_ff  <= left_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      sxx_ff   <= sxx_in;
      syy_ff   <= syy_in;
      sxy_ff   <= sxy_in;
      pa_ff    <= PW'(n_ff) * PW'(sxy_ff);
      pb_ff    <= PW'(sx_ff) * PW'(sy_ff);
      nxx_ff   <= PW'(n_ff) * PW'(sxx_ff);
      nyy_ff   <= PW'(n_ff) * PW'(syy_ff);
      sxsx_ff  <= PW'(sx_ff) * PW'(sx_ff);
      sysy_ff  <= PW'(sy_ff) * PW'(sy_ff);
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      acc_ff   <= acc_in;
      mca_ff   <= mca_in;
      mcb_ff   <= mcb_in;
      den_ff   <= den_in;
      nsq_ff   <= nsq_in;
      tden_ff  <= tden_in;
      s_ff     <= s_in;
      u_ff     <= u_in;
      d_ff     <= d_in;
      trial_ff <= trial_in;
      q_ff     <= q_in;
      bit_ff   <= bit_in;
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/windowed_size_correlation_detector.sv =====
// ============================================================================
// windowed_size_correlation_detector
// sliding window pearson correlation of incoming and outgoing packet sizes
// ============================================================================
// Requests enter on start when busy is low: req_type 0 records an incoming
// size, 1 an outgoing size, 2 asks for the correlation, 3 is dropped.
// Accepted requests go into a four-beat command queue; busy is high only
// while that queue is full.
// A record is written to its ring by the back part and gives no result.
// A query with too few samples gives its beat, through the queue and
// the result register, when the back part is idle.
// A full query walks min(count) ring pairs at one pair per cycle, then,
// unless a variance is zero, runs three products on a bit-serial
// multiplier (stepping through the bits of the second operand up to its
// top set bit) and a 16-bit search with a sum and a compare step per bit;
// records queued behind it wait.
// Each result is a one-cycle beat on rsp_valid; there is no stall input.
// Reset clears pointers, counts, queue and registers (window 1000,
// threshold 45875); ring contents are not cleared and need no clearing pass.
// ============================================================================
`default_nettype none

module windowed_size_correlation_detector #(
   parameter int MAX_WINDOW = wscd_pkg::DEF_MAX_WINDOW,
   parameter int SIZE_BITS  = wscd_pkg::DEF_SIZE_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [1:0]                            req_type,
   input  wire logic [wscd_pkg::PKT_BITS-1:0]         req_pkt_size,
   output logic                                       rsp_valid,
   output logic signed [wscd_pkg::CORR_BITS-1:0]      rsp_correlation,
   output logic                                       rsp_correlated,
   output logic                                       rsp_enough_samples,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [wscd_pkg::ADDR_BITS-1:0]        paddr,
   input  wire logic [wscd_pkg::CSR_BITS-1:0]         pwdata,
   output logic      [wscd_pkg::CSR_BITS-1:0]         prdata,
   output logic                                       pready
);

   localparam int SW = (SIZE_BITS < wscd_pkg::PKT_BITS) ? SIZE_BITS : wscd_pkg::PKT_BITS;
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int NW = $clog2(MAX_WINDOW + 1);
   localparam int QW = 2 + SW + 2 * AW + NW + 1;

   logic [wscd_pkg::WIN_BITS-1:0] window_ff, window_in;
   logic [wscd_pkg::THR_BITS-1:0] thresh_ff, thresh_in;
   logic                          csr_wr;
   logic                          q_full, q_empty, push, pop;
   logic [QW-1:0]                 push_data, head_data;
   wscd_pkg::rsp_type             rsp;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      window_in = window_ff;
      thresh_in = thresh_ff;
      if (csr_wr) begin
         case (paddr[2])
            wscd_pkg::REG_WINDOW: window_in = pwdata[wscd_pkg::WIN_BITS-1:0];
            wscd_pkg::REG_THRESH: thresh_in = pwdata[wscd_pkg::THR_BITS-1:0];
            default: window_in = window_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         wscd_pkg::REG_WINDOW: prdata = wscd_pkg::CSR_BITS'(window_ff);
         wscd_pkg::REG_THRESH: prdata = wscd_pkg::CSR_BITS'(thresh_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= wscd_pkg::WINDOW_RESET;
         thresh_ff <= wscd_pkg::THRESH_RESET;
      end else begin
         window_ff <= window_in;
         thresh_ff <= thresh_in;
      end
   end

   wscd_front #(.MAX_WINDOW(MAX_WINDOW), .SIZE_BITS(SIZE_BITS), .QW(QW)) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .q_full       (q_full),
      .req_type     (req_type),
      .req_pkt_size (req_pkt_size),
      .window_size  (window_ff),
      .busy         (busy),
      .push         (push),
      .push_data    (push_data)
   );

   wscd_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   wscd_back #(.MAX_WINDOW(MAX_WINDOW), .SIZE_BITS(SIZE_BITS), .QW(QW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_empty   (q_empty),
      .threshold (thresh_ff),
      .pop       (pop),
      .rsp       (rsp)
   );

   assign rsp_valid          = rsp.valid;
   assign rsp_correlation    = rsp.correlation;
   assign rsp_correlated     = rsp.correlated;
   assign rsp_enough_samples = rsp.enough_samples;

   a_short_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_enough_samples) |-> (rsp_correlation == '0 && !rsp_correlated))
      else $error("result without enough samples is not zero");

   a_flag_needs_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_correlated |-> (rsp_valid && rsp_enough_samples))
      else $error("correlated flag without a full result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or result beat right after reset");

endmodule

`default_nettype wire

// ===== tb/tb_windowed_size_correlation_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_size_correlation_detector
// self-checking bench for the windowed size correlation detector
// ----------------------------------------------------------------------------
// Drives record and query commands under several window and threshold
// settings, predicts each query answer with exact wide-integer Pearson
// arithmetic and compares every result beat field by field in order.
// ----------------------------------------------------------------------------

typedef struct {
   logic signed [wscd_pkg::CORR_BITS-1:0] correlation;
   logic                                  correlated;
   logic                                  enough_samples;
} answer_type;

class scoreboard_type;
   logic [wscd_pkg::PKT_BITS-1:0] in_ring[wscd_pkg::DEF_MAX_WINDOW];
   logic [wscd_pkg::PKT_BITS-1:0] out_ring[wscd_pkg::DEF_MAX_WINDOW];
   int unsigned in_oldest, in_count, out_oldest, out_count;
   int unsigned window;
   int unsigned thresh;
   answer_type  pending_answers[$];
   int          mismatches;
   int          queries;
   int          records;

   function new();
      window = wscd_pkg::WINDOW_RESET;
      thresh = wscd_pkg::THRESH_RESET;
   endfunction

   function void set_reg(logic sel, logic [wscd_pkg::CSR_BITS-1:0] value);
      if (sel == wscd_pkg::REG_WINDOW) window = value[wscd_pkg::WIN_BITS-1:0];
      else thresh = value[wscd_pkg::THR_BITS-1:0];
   endfunction

   function void add_size(bit outgoing, logic [wscd_pkg::PKT_BITS-1:0] size);
      int unsigned win;
      int unsigned oldest;
      int unsigned cnt;
      win = (window > wscd_pkg::DEF_MAX_WINDOW) ? wscd_pkg::DEF_MAX_WINDOW : window;
      oldest = outgoing ? out_oldest : in_oldest;
      cnt = outgoing ? out_count : in_count;
      if (outgoing) out_ring[(oldest + cnt) % wscd_pkg::DEF_MAX_WINDOW] = size;
      else in_ring[(oldest + cnt) % wscd_pkg::DEF_MAX_WINDOW] = size;
      cnt++;
      if (cnt > win) begin
         oldest = (oldest + (cnt - win)) % wscd_pkg::DEF_MAX_WINDOW;
         cnt = win;
      end
      if (outgoing) begin
         out_oldest = oldest;
         out_count = cnt;
      end else begin
         in_oldest = oldest;
         in_count = cnt;
      end
   endfunction

   function answer_type pearson();
      answer_type a;
      longint unsigned n, sx, sy, sxy, sx2, sy2, x, y, pa, pb, mag, va, vb;
      bit neg;
      bit [159:0] den, nsq, lhs, rhs;
      int unsigned lo, hi, mid;
      a.correlation = '0;
      a.correlated = 1'b0;
      a.enough_samples = 1'b0;
      if (in_count < wscd_pkg::MIN_SAMPLES || out_count < wscd_pkg::MIN_SAMPLES) return a;
      a.enough_samples = 1'b1;
      n = (in_count < out_count) ? in_count : out_count;
      sx = 0; sy = 0; sxy = 0; sx2 = 0; sy2 = 0;
      for (longint unsigned i = 0; i < n; i++) begin
         x = in_ring[(in_oldest + i) % wscd_pkg::DEF_MAX_WINDOW];
         y = out_ring[(out_oldest + i) % wscd_pkg::DEF_MAX_WINDOW];
         sx += x; sy += y; sxy += x * y; sx2 += x * x; sy2 += y * y;
      end
      pa = n * sxy;
      pb = sx * sy;
      neg = pa < pb;
      mag = neg ? pb - pa : pa - pb;
      va = n * sx2 - sx * sx;
      vb = n * sy2 - sy * sy;
      if (va == 0 || vb == 0) return a;
      den = 160'(va) * 160'(vb);
      nsq = 160'(mag) * 160'(mag);
      rhs = nsq << 30;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         lhs = den * 160'(mid * mid);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      if (neg) a.correlation = 16'(65536 - lo);
      else a.correlation = (lo > 32767) ? 16'sd32767 : 16'(lo);
      a.correlated = ((nsq << 32) > den * 160'(thresh * thresh));
      return a;
   endfunction

   function void note_command(wscd_pkg::op_type op, logic [wscd_pkg::PKT_BITS-1:0] size);
      case (op)
         wscd_pkg::OP_REC_IN: begin
            add_size(1'b0, size);
            records++;
         end
         wscd_pkg::OP_REC_OUT: begin
            add_size(1'b1, size);
            records++;
         end
         wscd_pkg::OP_QUERY: begin
            pending_answers.insert(pending_answers.size(), pearson());
            queries++;
         end
         default: ;
      endcase
   endfunction

   function void check_answer(logic signed [wscd_pkg::CORR_BITS-1:0] corr, logic cd,
                              logic es);
      answer_type e;
      if (pending_answers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result beat corr=%0d", corr);
         return;
      end
      e = pending_answers.pop_front();
      if (corr !== e.correlation || cd !== e.correlated || es !== e.enough_samples) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected corr=%0d cd=%0b es=%0b, got corr=%0d cd=%0b es=%0b",
                     e.correlation, e.correlated, e.enough_samples, corr, cd, es);
      end
   endfunction
endclass

module tb_windowed_size_correlation_detector;
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_type = wscd_pkg::OP_REC_IN;
   logic [wscd_pkg::PKT_BITS-1:0] req_pkt_size = '0;
   logic                   rsp_valid;
   logic signed [wscd_pkg::CORR_BITS-1:0] rsp_correlation;
   logic                   rsp_correlated;
   logic                   rsp_enough_samples;
   logic                   psel = 1'b0;
   logic                   penable = 1'b0;
   logic                   pwrite = 1'b0;
   logic [wscd_pkg::ADDR_BITS-1:0] paddr = '0;
   logic [wscd_pkg::CSR_BITS-1:0]  pwdata = '0;
   logic [wscd_pkg::CSR_BITS-1:0]  prdata;
   logic                   pready;

   scoreboard_type sb = new();
   int idle_pct = 0;

   windowed_size_correlation_detector u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_pkt_size(req_pkt_size),
      .rsp_valid(rsp_valid), .rsp_correlation(rsp_correlation),
      .rsp_correlated(rsp_correlated), .rsp_enough_samples(rsp_enough_samples),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_answer(rsp_correlation, rsp_correlated, rsp_enough_samples);
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send(wscd_pkg::op_type op, logic [wscd_pkg::PKT_BITS-1:0] size);
      start <= 1'b1;
      req_type <= op;
      req_pkt_size <= size;
      do @(posedge clock); while (busy);
      sb.note_command(op, size);
      @(negedge clock);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending_answers.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(logic sel, logic [wscd_pkg::CSR_BITS-1:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= (sel == wscd_pkg::REG_THRESH) ? wscd_pkg::ADDR_BITS'(4)
                                             : wscd_pkg::ADDR_BITS'(0);
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(sel, value);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic random_pair(int mode);
      logic [wscd_pkg::PKT_BITS-1:0] x, y;
      x = (mode == 4) ? wscd_pkg::PKT_BITS'($urandom_range(0, 20))
                      : wscd_pkg::PKT_BITS'($urandom);
      case (mode)
         0: y = wscd_pkg::PKT_BITS'($urandom);
         1: y = x + wscd_pkg::PKT_BITS'($urandom_range(0, 255));
         2: y = ~x;
         3: begin
            x = 16'd1500;
            y = wscd_pkg::PKT_BITS'($urandom);
         end
         4: y = x;
         default: y = x;
      endcase
      send(wscd_pkg::OP_REC_IN, x);
      send(wscd_pkg::OP_REC_OUT, y);
   endtask

   initial begin
      int windows[7] = '{16, 2047, 64, 12, 0, 1, 1024};
      int thresholds[7] = '{0, 65535, 60000, 45875, 32768, 100, 20000};
      int total;
      int mode;
      int r;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(wscd_pkg::OP_QUERY, 16'hFFFF);
      send(wscd_pkg::OP_NONE, 16'hFFFF);
      drain();
      csr_write(wscd_pkg::REG_WINDOW, 32'd10);
      for (int i = 0; i < 10; i++) begin
         send(wscd_pkg::OP_REC_IN,
              (i == 9) ? 16'hFFFF : wscd_pkg::PKT_BITS'(i * 6553));
         send(wscd_pkg::OP_REC_OUT,
              (i == 9) ? 16'h0000 : wscd_pkg::PKT_BITS'(65535 - i * 6553));
      end
      send(wscd_pkg::OP_QUERY, 16'h0);
      drain();

      total = 0;
      for (int ph = 0; ph < 7; ph++) begin
         csr_write(wscd_pkg::REG_WINDOW, wscd_pkg::CSR_BITS'(windows[ph]));
         csr_write(wscd_pkg::REG_THRESH, wscd_pkg::CSR_BITS'(thresholds[ph]));
         mode = $urandom_range(0, 4);
         for (int k = 0; k < 140; k++) begin
            idle_pct = (total < 600) ? 7 : (total < 1200) ? 60 : 0;
            r = $urandom_range(0, 99);
            if (r < 10) mode = $urandom_range(0, 4);
            if (r < 80) begin
               random_pair(mode);
               total += 2;
            end else if (r < 93) begin
               send(wscd_pkg::OP_QUERY, wscd_pkg::PKT_BITS'($urandom));
               total++;
            end else if (r < 96) begin
               send(wscd_pkg::OP_NONE, wscd_pkg::PKT_BITS'($urandom));
            end else begin
               send(wscd_pkg::op_type'($urandom_range(0, 1)),
                    wscd_pkg::PKT_BITS'($urandom));
               total++;
            end
         end
         send(wscd_pkg::OP_QUERY, 16'h0);
         drain();
      end

      $display("covered %0d records and %0d queries over 8 window/threshold settings",
               sb.records, sb.queries);
      if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
